[rtl/string_match_automaton_transitions_macros.svh]
// assertion macros for the string match automaton transition block
// depends on clk and rst being visible where a macro is used
`ifndef STRING_MATCH_AUTOMATON_TRANSITIONS_MACROS_SVH
`define STRING_MATCH_AUTOMATON_TRANSITIONS_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SMAT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smat check failed");
// next-cycle implication
`define SMAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smat check failed");
`else
`define SMAT_ASSERT_IMP(label, ante, cons)
`define SMAT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[rtl/smat_pkg.sv]
// shared types and constants for the string match automaton transition block
// no dependencies
package smat_pkg;

  // default sizes
  localparam int MAX_PATTERN_DEF = 32;
  localparam int MAX_SIGNALS_DEF = 64;

  // item kind codes
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } smat_status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_CMP,
    S_EMIT
  } smat_state_t;

  // compare unit control: compare against the signal instead of a second symbol
  typedef struct packed {
    logic       use_sig;
    logic [7:0] sig;
  } smat_cmp_ctl_t;

endpackage

[rtl/smat_cmd_if.sv]
// input item channel: valid/ready plus the load or query fields
// no dependencies
interface smat_cmd_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] symbol;
  logic       restart;
  logic [4:0] query_state;

  modport source (output valid, kind, symbol, restart, query_state, input ready);
  modport sink (input valid, kind, symbol, restart, query_state, output ready);
endinterface

[rtl/smat_res_if.sv]
// result item channel: valid/ready plus one transition entry
// no dependencies
interface smat_res_if;
  logic       valid;
  logic       ready;
  logic [5:0] signal_index;
  logic [5:0] next_state;
  logic       last;
  logic [1:0] status;

  modport source (output valid, signal_index, next_state, last, status, input ready);
  modport sink (input valid, signal_index, next_state, last, status, output ready);
endinterface

[rtl/smat_store.sv]
// pattern store with one write port, two registered read ports and the shared
// symbol comparator; depends on smat_pkg
module smat_store #(
  parameter int DEPTH = smat_pkg::MAX_PATTERN_DEF,
  parameter int AW    = $clog2(smat_pkg::MAX_PATTERN_DEF)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [7:0]              wr_data,
  input  logic [AW-1:0]           rd_addr_a,
  input  logic [AW-1:0]           rd_addr_b,
  input  smat_pkg::smat_cmp_ctl_t cmp_ctl,
  output logic                    match
);
  import smat_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_a;
  logic [7:0] rd_b;

  // write and registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  // compare the prefix symbol with either the shifted pattern symbol or the signal
  assign match = (rd_a == (cmp_ctl.use_sig ? cmp_ctl.sig : rd_b));

endmodule

[rtl/string_match_automaton_transitions.sv]
// top level: transition rows of a pattern-matching automaton, computed on demand
// depends on smat_pkg, smat_cmd_if, smat_res_if, smat_store and the macros header
//
//   channel  | dir | handshake      | payload
//   cmd      | in  | valid / ready  | kind, symbol, restart, query_state
//   res      | out | valid / ready  | signal_index, next_state, last, status
//   cfg      | in  | cfg_we         | cfg_data = signal_count
//
// a load is accepted, then its result goes into the output register
// a query takes, for each signal, an issue step and a compare step per symbol compare
// of the shift walk, then emits the entry
// the walk is bounded by the single compare unit and its registered store reads
// cmd is ready only while idle; a held result stalls the walk before the next entry
// rst clears the pattern length, signal count (to 2) and control; no clearing pass
`include "string_match_automaton_transitions_macros.svh"

module string_match_automaton_transitions #(
  parameter int MAX_PATTERN = smat_pkg::MAX_PATTERN_DEF,
  parameter int MAX_SIGNALS = smat_pkg::MAX_SIGNALS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  smat_cmd_if.sink   cmd,
  smat_res_if.source res,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data
);
  import smat_pkg::*;

  localparam int AW = $clog2(MAX_PATTERN);
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int SW = $clog2(MAX_SIGNALS);

  smat_state_t   state, state_next;
  logic [LW-1:0] pat_len, pat_len_next;
  logic [6:0]    sig_cnt;
  logic [AW-1:0] q_r, q_next;
  logic [AW-1:0] j, j_next;
  logic [AW-1:0] d, d_next;
  logic [SW-1:0] sig, sig_next;
  logic [SW-1:0] sig_last, sig_last_next;
  logic [5:0]    res_ns, res_ns_next;
  smat_status_t  res_status, res_status_next;
  logic          res_last, res_last_next;

  logic          ov;
  logic [5:0]    o_idx;
  logic [5:0]    o_ns;
  logic          o_last;
  smat_status_t  o_status;

  logic [LW-1:0] len_eff;
  logic          q_ok;
  logic [SW-1:0] n_minus1;
  logic [AW-1:0] diag;
  logic [LW-1:0] k_val;
  logic          emit_fire;
  logic          wr_en;
  logic          match;
  smat_cmp_ctl_t cmp_ctl;

  // pattern store and compare unit
  smat_store #(
    .DEPTH (MAX_PATTERN),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (AW'(len_eff)),
    .wr_data   (cmd.symbol),
    .rd_addr_a (j),
    .rd_addr_b (AW'(j + d)),
    .cmp_ctl   (cmp_ctl),
    .match     (match)
  );

  // derived values
  assign len_eff   = cmd.restart ? '0 : pat_len;
  assign q_ok      = (32'(cmd.query_state) < 32'(pat_len));
  assign diag      = AW'(q_r - d);
  assign k_val     = LW'(LW'(q_r) - LW'(d) + LW'(1));
  assign emit_fire = (state == S_EMIT) && (!ov || res.ready);

  always_comb begin
    if (sig_cnt == 7'd0) begin
      n_minus1 = '0;
    end else if (sig_cnt > 7'(MAX_SIGNALS)) begin
      n_minus1 = SW'(MAX_SIGNALS - 1);
    end else begin
      n_minus1 = SW'(sig_cnt - 7'd1);
    end
  end

  // the last symbol of each candidate prefix is checked against the signal
  assign cmp_ctl.use_sig = (j == diag);
  assign cmp_ctl.sig     = 8'(sig);

  // sequencer
  always_comb begin
    state_next      = state;
    pat_len_next    = pat_len;
    q_next          = q_r;
    j_next          = j;
    d_next          = d;
    sig_next        = sig;
    sig_last_next   = sig_last;
    res_ns_next     = res_ns;
    res_status_next = res_status;
    res_last_next   = res_last;
    wr_en           = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          sig_next      = '0;
          res_last_next = 1'b1;
          state_next    = S_EMIT;
          if (cmd.kind == KIND_LOAD) begin
            if (len_eff == LW'(MAX_PATTERN)) begin
              pat_len_next    = len_eff;
              res_ns_next     = 6'(len_eff);
              res_status_next = ST_FULL;
            end else begin
              wr_en           = 1'b1;
              pat_len_next    = LW'(len_eff + LW'(1));
              res_ns_next     = 6'(LW'(len_eff + LW'(1)));
              res_status_next = ST_OK;
            end
          end else if (!q_ok) begin
            res_ns_next     = '0;
            res_status_next = ST_RANGE;
          end else begin
            q_next          = AW'(cmd.query_state);
            j_next          = AW'(cmd.query_state);
            d_next          = '0;
            sig_last_next   = n_minus1;
            res_status_next = ST_OK;
            state_next      = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (match) begin
          if (j == '0) begin
            // whole candidate prefix matches
            res_ns_next   = 6'(k_val);
            res_last_next = (sig == sig_last);
            state_next    = S_EMIT;
          end else begin
            j_next     = AW'(j - AW'(1));
            state_next = S_ISSUE;
          end
        end else if (d == q_r) begin
          // no prefix fits
          res_ns_next   = '0;
          res_last_next = (sig == sig_last);
          state_next    = S_EMIT;
        end else begin
          // try the next shorter prefix
          d_next     = AW'(d + AW'(1));
          j_next     = AW'(diag - AW'(1));
          state_next = S_ISSUE;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          if (res_last) begin
            state_next = S_IDLE;
          end else begin
            sig_next   = SW'(sig + SW'(1));
            j_next     = q_r;
            d_next     = '0;
            state_next = S_ISSUE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pat_len <= '0;
      sig_cnt <= 7'd2;
      ov      <= 1'b0;
    end else begin
      state   <= state_next;
      pat_len <= pat_len_next;
      if (cfg_we) begin
        sig_cnt <= cfg_data;
      end
      if (emit_fire) begin
        ov <= 1'b1;
      end else if (res.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    q_r        <= q_next;
    j          <= j_next;
    d          <= d_next;
    sig        <= sig_next;
    sig_last   <= sig_last_next;
    res_ns     <= res_ns_next;
    res_status <= res_status_next;
    res_last   <= res_last_next;
    if (emit_fire) begin
      o_idx    <= 6'(sig);
      o_ns     <= res_ns;
      o_last   <= res_last;
      o_status <= res_status;
    end
  end

  // ports
  assign cmd.ready        = (state == S_IDLE);
  assign res.valid        = ov;
  assign res.signal_index = o_idx;
  assign res.next_state   = o_ns;
  assign res.last         = o_last;
  assign res.status       = o_status;

  // checks
  `SMAT_ASSERT_IMP(a_len_bound, 1'b1, 32'(pat_len) <= 32'(MAX_PATTERN))
  `SMAT_ASSERT_IMP(a_walk_bound, state == S_ISSUE, (32'(j) + 32'(d)) <= 32'(q_r))
  `SMAT_ASSERT_NEXT(a_row_end, emit_fire && res_last, state == S_IDLE)
  `SMAT_ASSERT_IMP(a_query_len, state == S_CMP, 32'(q_r) < 32'(pat_len))

endmodule

[bench/testbench.sv]
// testbench for the string match automaton transition block: loads patterns,
// queries transition rows and checks every entry against a predictor of its own
// depends on smat_pkg, smat_cmd_if, smat_res_if and string_match_automaton_transitions

// one expected transition entry
typedef struct packed {
  logic [5:0]             signal_index;
  logic [5:0]             next_state;
  logic                   last;
  smat_pkg::smat_status_t status;
} row_entry_t;

// pattern copy, signal count and the entries still owed by the block
class transition_rows;
  logic [7:0]  pattern [smat_pkg::MAX_PATTERN_DEF];
  int unsigned pattern_len;
  logic [6:0]  signal_count;
  row_entry_t  pending_entries [$];
  int unsigned mismatches;

  function new();
    pattern_len = 0;
    signal_count = 7'd2;
    mismatches = 0;
  endfunction

  function void take_signal_count(logic [6:0] value);
    signal_count = value;
  endfunction

  // q+1 on a direct match, else longest prefix ending pattern[0..q-1] plus sig
  function int unsigned next_state_for(int unsigned q, int unsigned sig);
    int unsigned k, i;
    bit agree;
    if (pattern[q] == sig) return q + 1;
    for (k = q; k > 0; k--) begin
      agree = (pattern[k - 1] == sig);
      for (i = 0; agree && i + 1 < k; i++)
        agree = (pattern[i] == pattern[q - k + 1 + i]);
      if (agree) return k;
    end
    return 0;
  endfunction

  function void owe_entry(int unsigned idx, int unsigned nxt, bit last,
                          smat_pkg::smat_status_t st);
    row_entry_t e;
    e.signal_index = 6'(idx);
    e.next_state = 6'(nxt);
    e.last = last;
    e.status = st;
    pending_entries.push_back(e);
  endfunction

  // accepted item: update the pattern and queue the entries it causes
  function void note_item(logic kind, logic [7:0] symbol, logic restart,
                          logic [4:0] query_state);
    int unsigned columns, s;
    if (kind == smat_pkg::KIND_LOAD) begin
      if (restart) pattern_len = 0;
      if (pattern_len >= smat_pkg::MAX_PATTERN_DEF) begin
        owe_entry(0, pattern_len, 1'b1, smat_pkg::ST_FULL);
      end else begin
        pattern[pattern_len] = symbol;
        pattern_len++;
        owe_entry(0, pattern_len, 1'b1, smat_pkg::ST_OK);
      end
    end else if (query_state >= pattern_len) begin
      owe_entry(0, 0, 1'b1, smat_pkg::ST_RANGE);
    end else begin
      columns = signal_count;
      if (columns == 0) columns = 1;
      if (columns > smat_pkg::MAX_SIGNALS_DEF) columns = smat_pkg::MAX_SIGNALS_DEF;
      for (s = 0; s < columns; s++)
        owe_entry(s, next_state_for(query_state, s), s + 1 == columns, smat_pkg::ST_OK);
    end
  endfunction

  // compare one accepted result with the oldest owed entry
  function void check_result(logic [5:0] signal_index, logic [5:0] next_state,
                             logic last, logic [1:0] status);
    row_entry_t e;
    if (pending_entries.size() == 0) begin
      $error("unexpected result: signal_index %0d next_state %0d last %0d status %0d",
             signal_index, next_state, last, status);
      mismatches++;
      return;
    end
    e = pending_entries.pop_front();
    if (signal_index !== e.signal_index) begin
      $error("signal_index: expected %0d, got %0d", e.signal_index, signal_index);
      mismatches++;
    end
    if (next_state !== e.next_state) begin
      $error("next_state: expected %0d, got %0d", e.next_state, next_state);
      mismatches++;
    end
    if (last !== e.last) begin
      $error("last: expected %0d, got %0d", e.last, last);
      mismatches++;
    end
    if (status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, status);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned TARGET_ITEMS = 450;
  localparam int unsigned SETTLE_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [6:0]  cfg_data;
  logic        sink_ready = 1'b0;
  logic        rx_stalls_on = 1'b1;
  bit          tx_gaps_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned phase = 0;
  logic [6:0]  count;

  transition_rows board = new();

  smat_cmd_if cmd ();
  smat_res_if res ();

  assign res.ready = sink_ready;

  string_match_automaton_transitions u_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      board.check_result(res.signal_index, res.next_state, res.last, res.status);
  end

  // result sink with random stalls, mostly short
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
    end else if (stall_left != 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_stalls_on && $urandom_range(0, 99) < 30) begin
      sink_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // send one item and wait for its acceptance
  task automatic push_item(logic kind, logic [7:0] symbol, logic restart,
                           logic [4:0] query_state);
    int unsigned gap;
    gap = gap_length();
    if (gap != 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.kind <= kind;
    cmd.symbol <= symbol;
    cmd.restart <= restart;
    cmd.query_state <= query_state;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    board.note_item(kind, symbol, restart, query_state);
    items_sent++;
  endtask

  // query_state is ignored on loads, so it gets random bits
  task automatic load_symbol(logic [7:0] symbol, logic restart);
    push_item(smat_pkg::KIND_LOAD, symbol, restart, 5'($urandom_range(0, 31)));
  endtask

  // symbol and restart are ignored on queries
  task automatic query_row(logic [4:0] state);
    push_item(smat_pkg::KIND_QUERY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              state);
  endtask

  // let every owed entry come back with the command channel idle
  task automatic drain_rows();
    cmd.valid <= 1'b0;
    while (board.pending_entries.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_signal_count(logic [6:0] value);
    drain_rows();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.take_signal_count(value);
  endtask

  // mostly a small alphabet so rows see matches and fallbacks, a few wide symbols
  function automatic logic [7:0] pick_symbol(int unsigned alpha);
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, alpha - 1));
  endfunction

  function automatic logic [6:0] pick_signal_count();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return 7'($urandom_range(1, 6));
    if (r == 14) return 7'd0;
    if (r == 15) return 7'd1;
    if (r == 16) return 7'd64;
    if (r == 17) return 7'd127;
    return 7'($urandom_range(0, 127));
  endfunction

  // fresh pattern, then queries with some appends, restarts and stray states
  task automatic random_phase(logic [6:0] cols);
    int unsigned len, alpha, steps, i;
    bit restart;
    len = (cols <= 8 && $urandom_range(0, 7) == 0) ? $urandom_range(9, 16)
                                                   : $urandom_range(1, 8);
    alpha = $urandom_range(1, 4);
    for (i = 0; i < len; i++) load_symbol(pick_symbol(alpha), i == 0);
    steps = $urandom_range(3, 10);
    for (i = 0; i < steps; i++) begin
      case ($urandom_range(0, 9))
        0: query_row(5'($urandom_range(0, 31)));
        1: begin
          restart = ($urandom_range(0, 2) == 0);
          load_symbol(pick_symbol(alpha), restart);
          len = restart ? 1 : len + 1;
        end
        default: query_row(5'($urandom_range(0, len - 1)));
      endcase
    end
  endtask

  // fill the store, overflow it, query the deepest state, then restart it
  task automatic full_store_phase();
    int unsigned i;
    set_signal_count(7'd64);
    for (i = 0; i < smat_pkg::MAX_PATTERN_DEF; i++)
      load_symbol(8'($urandom_range(0, 1)), i == 0);
    load_symbol(8'hff, 1'b0);
    load_symbol(8'h00, 1'b0);
    query_row(5'd31);
    set_signal_count(7'd3);
    query_row(5'd30);
    query_row(5'($urandom_range(0, 31)));
    load_symbol(8'd2, 1'b1);
    query_row(5'd0);
  endtask

  initial begin
    cmd.valid <= 1'b0;
    cmd.kind <= smat_pkg::KIND_LOAD;
    cmd.symbol <= 8'd0;
    cmd.restart <= 1'b0;
    cmd.query_state <= 5'd0;
    cfg_we <= 1'b0;
    cfg_data <= 7'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty pattern, so any state is out of range
    query_row(5'd0);
    // pattern 0101 with two signals
    load_symbol(8'd0, 1'b1);
    load_symbol(8'd1, 1'b0);
    load_symbol(8'd0, 1'b0);
    load_symbol(8'd1, 1'b0);
    query_row(5'd0);
    query_row(5'd1);
    query_row(5'd2);
    query_row(5'd3);
    query_row(5'd4);
    query_row(5'd31);
    // wide symbols never match any signal
    load_symbol(8'hff, 1'b1);
    load_symbol(8'd64, 1'b0);
    load_symbol(8'd0, 1'b0);
    load_symbol(8'd63, 1'b0);
    // count above the maximum acts as the maximum
    set_signal_count(7'd127);
    query_row(5'd2);
    query_row(5'd3);
    // zero count acts as one signal
    set_signal_count(7'd0);
    query_row(5'd3);
    query_row(5'd0);

    full_store_phase();

    // random phases with fresh count and idling choices
    while (items_sent < TARGET_ITEMS) begin
      count = pick_signal_count();
      set_signal_count(count);
      tx_gaps_on = ($urandom_range(0, 2) != 0);
      rx_stalls_on <= ($urandom_range(0, 2) != 0);
      random_phase(count);
      phase++;
      if (phase == 15) full_store_phase();
    end

    drain_rows();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
